[hdl/bbh_pkg.sv]
//------------------------------------------------------------------------------
// bbh_pkg
// Shared types, operation codes and arithmetic constants of the Breslow
// baseline hazard estimator.
//------------------------------------------------------------------------------
`default_nettype none
package bbh_pkg;

  localparam int MAX_PATIENTS_DEF = 1024;
  localparam int MAX_EVENTS_DEF   = 64;

  localparam logic [1:0] OP_LOAD_PAT = 2'd0;
  localparam logic [1:0] OP_LOAD_EV  = 2'd1;
  localparam logic [1:0] OP_START    = 2'd2;
  localparam logic [1:0] OP_RSVD     = 2'd3;

  localparam int TIME_W = 32;
  localparam int WGT_W  = 40;
  localparam int TOT_W  = 50;
  localparam int HAZ_W  = 48;

  localparam logic [HAZ_W-1:0] HAZ_MAX = {HAZ_W{1'b1}};
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  typedef struct packed {
    logic [1:0]          op;
    logic [TIME_W-1:0]   ptime;
    logic [3:0]          status;
    logic signed [12:0]  score;
    logic [TIME_W-1:0]   etime;
  } item_t;

  // ceil(2^35 / k) for the Horner divisions by k = 1 .. 11.
  function automatic logic [35:0] recip(input logic [3:0] k);
    logic [35:0] r;
    unique case (k)
      4'd1:    r = 36'd34359738368;
      4'd2:    r = 36'd17179869184;
      4'd3:    r = 36'd11453246123;
      4'd4:    r = 36'd8589934592;
      4'd5:    r = 36'd6871947674;
      4'd6:    r = 36'd5726623062;
      4'd7:    r = 36'd4908534053;
      4'd8:    r = 36'd4294967296;
      4'd9:    r = 36'd3817748708;
      4'd10:   r = 36'd3435973837;
      4'd11:   r = 36'd3123612579;
      default: r = 36'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/bbh_front.sv]
//------------------------------------------------------------------------------
// bbh_front
// Accepts input transfers, drops the reserved operation and holds the rest in
// a two-entry queue for the back end.
//------------------------------------------------------------------------------
`default_nettype none
module bbh_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [87:0]   in_tdata,
  input  wire logic [1:0]    in_tuser,
  output bbh_pkg::item_t     q_item,
  output logic               q_valid,
  input  wire logic          q_pop
);

  bbh_pkg::item_t ent_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     cnt_r;
  logic           push, pop;
  bbh_pkg::item_t new_item;

  assign in_tready = (cnt_r != 2'd2);
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = ent_r[rd_ptr_r];
  assign pop       = q_pop && q_valid;
  assign push      = in_tvalid && in_tready && (in_tuser != bbh_pkg::OP_RSVD);

  always_comb begin
    new_item.op     = in_tuser;
    new_item.ptime  = in_tdata[31:0];
    new_item.status = in_tdata[35:32];
    new_item.score  = in_tdata[48:36];
    new_item.etime  = in_tdata[80:49];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= new_item;
  end

endmodule
`default_nettype wire

[hdl/bbh_exp.sv]
//------------------------------------------------------------------------------
// bbh_exp
// Fixed-point exponential: Q4.8 linear predictor in, Q24.16 weight out, by an
// 11-term Horner series of 2^f with one multiply per cycle.
//------------------------------------------------------------------------------
`default_nettype none
module bbh_exp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [12:0] score,
  output logic                    done,
  output logic [39:0]             weight
);

  typedef enum logic [2:0] {E_IDLE, E_T30, E_MUL, E_DIV, E_SHIFT} exp_state_t;

  localparam logic signed [39:0] LOG2E_Q24 = 40'sd24204406;
  localparam logic [39:0]        U_BIAS    = 40'h30_0000_0000;

  exp_state_t  state_r;
  logic [39:0] u_r;
  logic [29:0] t30_r;
  logic [61:0] prod_r;
  logic [31:0] quo_r;
  logic [3:0]  k_r;
  logic        done_r;
  logic [39:0] w_r;

  logic signed [39:0] ys;
  logic [39:0]        u_nxt;
  logic [63:0]        fl;
  logic [31:0]        mval;
  logic [67:0]        qprod;
  logic [6:0]         hi;
  logic [5:0]         s;
  logic [40:0]        wl;
  logic [39:0]        rnd;
  logic [39:0]        w_nxt;

  always_comb begin
    ys    = 40'(score) * LOG2E_Q24;
    u_nxt = ys + U_BIAS;
    fl    = u_r[31:0] * bbh_pkg::LN2_Q32;
    mval  = bbh_pkg::ONE_Q30 + quo_r;
    qprod = prod_r[61:30] * bbh_pkg::recip(k_r);
    hi    = u_r[38:32];
    s     = 6'(7'd62 - hi);
    wl    = {9'd0, mval} << (hi - 7'd62);
    rnd   = 40'(mval) + (40'd1 << (s - 6'd1));
    if (hi >= 7'd62) begin
      w_nxt = wl[39:0];
    end else begin
      w_nxt = rnd >> s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        E_IDLE: begin
          if (start) begin
            u_r     <= u_nxt;
            state_r <= E_T30;
          end
        end
        E_T30: begin
          t30_r   <= fl[63:34];
          quo_r   <= 32'd0;
          k_r     <= 4'd11;
          state_r <= E_MUL;
        end
        E_MUL: begin
          prod_r  <= mval * t30_r;
          state_r <= E_DIV;
        end
        E_DIV: begin
          quo_r <= qprod[66:35];
          if (k_r == 4'd1) begin
            state_r <= E_SHIFT;
          end else begin
            k_r     <= k_r - 4'd1;
            state_r <= E_MUL;
          end
        end
        E_SHIFT: begin
          w_r     <= w_nxt;
          done_r  <= 1'b1;
          state_r <= E_IDLE;
        end
        default: state_r <= E_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign weight = w_r;

endmodule
`default_nettype wire

[hdl/bbh_div.sv]
//------------------------------------------------------------------------------
// bbh_div
// Restoring divider: floor(num * 2^48 / den), one quotient bit per cycle.
//------------------------------------------------------------------------------
`default_nettype none
module bbh_div #(
  parameter int NUM_W = 11
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [49:0]      den,
  output logic                  done,
  output logic [47:0]           quo
);

  logic        busy_r, done_r;
  logic [5:0]  cnt_r;
  logic [50:0] r_r;
  logic [47:0] q_r;
  logic [50:0] r2;
  logic        ge;

  always_comb begin
    r2 = {r_r[49:0], 1'b0};
    ge = (r2 >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd0;
        r_r    <= 51'(num);
        q_r    <= 48'd0;
      end else if (busy_r) begin
        r_r   <= ge ? (r2 - {1'b0, den}) : r2;
        q_r   <= {q_r[46:0], ge};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd47) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule
`default_nettype wire

[hdl/bbh_back.sv]
//------------------------------------------------------------------------------
// bbh_back
// Executes queued operations: stores patient records and event times, and on
// start walks the patients per event time and accumulates the hazard.
//------------------------------------------------------------------------------
`default_nettype none
module bbh_back #(
  parameter int MAX_PATIENTS = bbh_pkg::MAX_PATIENTS_DEF,
  parameter int MAX_EVENTS   = bbh_pkg::MAX_EVENTS_DEF,
  localparam int PCW = $clog2(MAX_PATIENTS + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  bbh_pkg::item_t          q_item,
  input  wire logic               q_valid,
  output logic                    q_pop,
  input  wire logic [3:0]         cause,
  output logic                    exp_start,
  output logic signed [12:0]      exp_score,
  input  wire logic               exp_done,
  input  wire logic [39:0]        exp_weight,
  output logic                    div_start,
  output logic [PCW-1:0]          div_num,
  output logic [49:0]             div_den,
  input  wire logic               div_done,
  input  wire logic [47:0]        div_quo,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [79:0]             out_tdata,
  output logic                    out_tuser,
  output logic                    out_tlast
);

  localparam int PAW = (MAX_PATIENTS > 1) ? $clog2(MAX_PATIENTS) : 1;
  localparam int ECW = $clog2(MAX_EVENTS + 1);
  localparam int EAW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;

  typedef struct packed {
    logic [31:0] ptime;
    logic [3:0]  status;
    logic [39:0] weight;
  } pat_t;

  typedef enum logic [2:0] {
    B_IDLE, B_EXP, B_EV_RD, B_EV_GET, B_PAT, B_CHECK, B_DIV, B_OUT
  } back_state_t;

  pat_t        pat_mem [MAX_PATIENTS];
  logic [31:0] ev_mem  [MAX_EVENTS];
  pat_t        pat_q;
  logic [31:0] ev_q;

  back_state_t state_r;
  logic [PCW-1:0] pcount_r, pidx_r, deaths_r;
  logic [ECW-1:0] ecount_r, eidx_r;
  logic [49:0]    total_r, snap_r;
  logic [47:0]    hazard_r;
  logic           sat_r, first_r;
  logic [31:0]    et_r, ld_time_r;
  logic [3:0]     ld_status_r;
  logic           out_valid_r, out_sat_r, out_last_r;
  logic [31:0]    out_time_r;
  logic [47:0]    out_haz_r;

  logic           pat_we, ev_we;
  logic [PAW-1:0] pat_rd_addr;
  logic [PCW-1:0] pidx_inc;
  logic [48:0]    sum;
  logic           out_free;
  logic           is_last;

  always_comb begin
    pidx_inc    = pidx_r + PCW'(1);
    pat_rd_addr = (state_r == B_PAT) ? pidx_inc[PAW-1:0] : pidx_r[PAW-1:0];
    pat_we      = (state_r == B_EXP) && exp_done;
    ev_we       = (state_r == B_IDLE) && q_valid && (q_item.op == bbh_pkg::OP_LOAD_EV)
                  && (ecount_r < ECW'(MAX_EVENTS));
    q_pop       = (state_r == B_IDLE) && q_valid;
    exp_start   = q_pop && (q_item.op == bbh_pkg::OP_LOAD_PAT)
                  && (pcount_r < PCW'(MAX_PATIENTS));
    exp_score   = q_item.score;
    div_start   = (state_r == B_CHECK) && (snap_r != 50'd0)
                  && (50'(deaths_r) < snap_r);
    div_num     = deaths_r;
    div_den     = snap_r;
    sum         = {1'b0, hazard_r} + {1'b0, div_quo};
    out_free    = !out_valid_r || out_tready;
    is_last     = (eidx_r + ECW'(1)) == ecount_r;
  end

  always_ff @(posedge clk) begin
    if (pat_we) pat_mem[pcount_r[PAW-1:0]] <= '{ptime: ld_time_r, status: ld_status_r,
                                                 weight: exp_weight};
    pat_q <= pat_mem[pat_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ev_we) ev_mem[ecount_r[EAW-1:0]] <= q_item.etime;
    ev_q <= ev_mem[eidx_r[EAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      pcount_r    <= '0;
      ecount_r    <= '0;
      total_r     <= '0;
      hazard_r    <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_tready && (state_r != B_OUT)) out_valid_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            unique case (q_item.op)
              bbh_pkg::OP_LOAD_PAT: begin
                ld_time_r   <= q_item.ptime;
                ld_status_r <= q_item.status;
                if (exp_start) state_r <= B_EXP;
              end
              bbh_pkg::OP_LOAD_EV: begin
                if (ev_we) ecount_r <= ecount_r + ECW'(1);
              end
              bbh_pkg::OP_START: begin
                pidx_r   <= '0;
                eidx_r   <= '0;
                hazard_r <= '0;
                sat_r    <= 1'b0;
                if (ecount_r != '0) begin
                  state_r <= B_EV_RD;
                end else begin
                  pcount_r <= '0;
                  total_r  <= '0;
                end
              end
              default: state_r <= B_IDLE;
            endcase
          end
        end
        B_EXP: begin
          if (exp_done) begin
            total_r  <= total_r + 50'(exp_weight);
            pcount_r <= pcount_r + PCW'(1);
            state_r  <= B_IDLE;
          end
        end
        B_EV_RD: state_r <= B_EV_GET;
        B_EV_GET: begin
          et_r     <= ev_q;
          snap_r   <= total_r;
          deaths_r <= '0;
          first_r  <= 1'b1;
          state_r  <= (pidx_r < pcount_r) ? B_PAT : B_CHECK;
        end
        B_PAT: begin
          // The first patient of an event time is taken whatever its time.
          if (first_r || (pat_q.ptime == et_r)) begin
            if (pat_q.status == cause) deaths_r <= deaths_r + PCW'(1);
            total_r <= total_r - 50'(pat_q.weight);
            pidx_r  <= pidx_inc;
            first_r <= 1'b0;
            if (!(pidx_inc < pcount_r)) state_r <= B_CHECK;
          end else begin
            state_r <= B_CHECK;
          end
        end
        B_CHECK: begin
          if (div_start) begin
            state_r <= B_DIV;
          end else begin
            hazard_r <= bbh_pkg::HAZ_MAX;
            sat_r    <= 1'b1;
            state_r  <= B_OUT;
          end
        end
        B_DIV: begin
          if (div_done) begin
            if (sum[48]) begin
              hazard_r <= bbh_pkg::HAZ_MAX;
              sat_r    <= 1'b1;
            end else begin
              hazard_r <= sum[47:0];
            end
            state_r <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_time_r  <= et_r;
            out_haz_r   <= hazard_r;
            out_sat_r   <= sat_r;
            out_last_r  <= is_last;
            eidx_r      <= eidx_r + ECW'(1);
            if (is_last) begin
              pcount_r <= '0;
              ecount_r <= '0;
              total_r  <= '0;
              hazard_r <= '0;
              state_r  <= B_IDLE;
            end else begin
              state_r <= B_EV_RD;
            end
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_haz_r, out_time_r};
  assign out_tuser  = out_sat_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

[hdl/breslow_baseline_hazard_top.sv]
//------------------------------------------------------------------------------
// breslow_baseline_hazard_top
// Breslow baseline cumulative hazard estimator with an input queue, a
// fixed-point exponential unit and a restoring divider.
//
//   Channel  Ports                          Carries
//   in       in_tvalid/tready/tdata/tuser   patient record, event time, start
//   out      out_tvalid/tready/tdata/tuser  event time, hazard, saturated, last
//   cfg      cfg_valid/ready/data           cause code
//
// A patient load holds the back end until the exponential unit is done (eleven
// Horner steps, each a multiply and a reciprocal multiply). A start visits, per
// event time, the event store and each patient examined in turn, and then the
// one-bit-per-cycle divider when it runs.
// Reset is synchronous; the stores need no clearing pass. A stalled result
// output holds the back end, while the two-entry queue takes input until it is full.
//------------------------------------------------------------------------------
`default_nettype none
module breslow_baseline_hazard_top #(
  parameter int MAX_PATIENTS = bbh_pkg::MAX_PATIENTS_DEF,
  parameter int MAX_EVENTS   = bbh_pkg::MAX_EVENTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // patient_time, patient_status, risk_score, event_time, zero pad
  input  wire logic [87:0] in_tdata,
  // operation
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_time, cumulative_hazard
  output logic [79:0]      out_tdata,
  // saturated
  output logic             out_tuser,
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data
);

  localparam int PCW = $clog2(MAX_PATIENTS + 1);

  logic [3:0]         cause_r;
  bbh_pkg::item_t     q_item;
  logic               q_valid, q_pop;
  logic               exp_start, exp_done;
  logic signed [12:0] exp_score;
  logic [39:0]        exp_weight;
  logic               div_start, div_done;
  logic [PCW-1:0]     div_num;
  logic [49:0]        div_den;
  logic [47:0]        div_quo;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cause_r <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      cause_r <= cfg_data;
    end
  end

  bbh_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .q_item, .q_valid, .q_pop
  );

  bbh_exp u_exp (
    .clk, .rst_n, .start(exp_start), .score(exp_score),
    .done(exp_done), .weight(exp_weight)
  );

  bbh_div #(.NUM_W(PCW)) u_div (
    .clk, .rst_n, .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  bbh_back #(.MAX_PATIENTS(MAX_PATIENTS), .MAX_EVENTS(MAX_EVENTS)) u_back (
    .clk, .rst_n, .q_item, .q_valid, .q_pop, .cause(cause_r),
    .exp_start, .exp_score, .exp_done, .exp_weight,
    .div_start, .div_num, .div_den, .div_done, .div_quo,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

`ifndef SYNTHESIS
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(exp_done && div_done))
    else $error("exponential and divider finished together");

  a_stall_means_queued: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> q_valid)
    else $error("input stalled with an empty queue");

  a_no_start_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    exp_start |=> !exp_start)
    else $error("exponential started on consecutive cycles");
`endif

endmodule
`default_nettype wire
